// ----- rtl/core/ebrb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrb_pkg
// Shared widths, codes and defaults of the line framed byte ring buffer.
// ----------------------------------------------------------------------------
package ebrb_pkg;

  localparam int DEPTH_DEF    = 64;
  localparam int BYTE_W       = 8;
  localparam int ACTION_W     = 2;
  localparam int MAXLEN_W     = 7;
  localparam int STATUS_W     = 3;
  localparam int LINELEN_W    = 6;
  localparam int LINELEN_MAX  = 63;

  localparam logic [BYTE_W-1:0] EOL_RESET = 8'd10;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH  = 2'd0,
    ACT_GET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NO_DATA     = 3'd1,
    ST_NO_EOL      = 3'd2,
    ST_NO_EOL_FULL = 3'd3,
    ST_TOO_LONG    = 3'd4,
    ST_FULL        = 3'd5
  } status_t;

endpackage

// ----- rtl/core/ebrb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ebrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/core/ebrb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebrb_ctrl
// Pointer bookkeeping, end-of-line search and line copy sequencer.
// ----------------------------------------------------------------------------
module ebrb_ctrl #(
  parameter int DEPTH = ebrb_pkg::DEPTH_DEF,
  localparam int PW   = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ebrb_pkg::ACTION_W-1:0]  in_action,
  input  logic [ebrb_pkg::BYTE_W-1:0]    in_data_in,
  input  logic [ebrb_pkg::MAXLEN_W-1:0]  in_max_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ebrb_pkg::STATUS_W-1:0]  out_status,
  output logic [ebrb_pkg::BYTE_W-1:0]    out_data_out,
  output logic [ebrb_pkg::LINELEN_W-1:0] out_line_length,
  output logic                           out_last,
  input  logic                           cfg_wr_en,
  input  logic [ebrb_pkg::BYTE_W-1:0]    cfg_wr_data,
  output logic                           ram_wr_en,
  output logic [PW-1:0]                  ram_wr_addr,
  output logic [ebrb_pkg::BYTE_W-1:0]    ram_wr_data,
  output logic                           ram_rd_en,
  output logic [PW-1:0]                  ram_rd_addr,
  input  logic [ebrb_pkg::BYTE_W-1:0]    ram_rd_data
);

  localparam int CMPW = (PW > ebrb_pkg::MAXLEN_W) ? PW : ebrb_pkg::MAXLEN_W;
  localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
  localparam logic [PW:0]     DEPTH_X  = (PW + 1)'(DEPTH);
  localparam logic [CMPW-1:0] LL_MAX   = CMPW'(ebrb_pkg::LINELEN_MAX);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SRD  = 6'b000010,
    S_SCMP = 6'b000100,
    S_LCHK = 6'b001000,
    S_CRD  = 6'b010000,
    S_CEM  = 6'b100000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [PW-1:0]                    wp_r, wp_nxt;
  logic [PW-1:0]                    rp_r, rp_nxt;
  logic [PW-1:0]                    sp_r, sp_nxt;
  logic [PW-1:0]                    cp_r, cp_nxt;
  logic [PW-1:0]                    fill_r, fill_nxt;
  logic [PW-1:0]                    len_r, len_nxt;
  logic [PW-1:0]                    rem_r, rem_nxt;
  logic                             rdy_r, rdy_nxt;
  logic [ebrb_pkg::BYTE_W-1:0]      eol_r, eol_nxt;
  logic [ebrb_pkg::MAXLEN_W-1:0]    maxlen_r, maxlen_nxt;
  logic                             ov_r, ov_nxt;
  logic [ebrb_pkg::STATUS_W-1:0]    ost_r, ost_nxt;
  logic [ebrb_pkg::BYTE_W-1:0]      odat_r, odat_nxt;
  logic [ebrb_pkg::LINELEN_W-1:0]   olen_r, olen_nxt;
  logic                             olast_r, olast_nxt;

  logic                             out_free;
  logic                             in_acc;
  logic [PW-1:0]                    sp_inc;
  logic [PW-1:0]                    cp_inc;
  logic [PW:0]                      line_span;
  logic [CMPW-1:0]                  len_x;
  logic [CMPW-1:0]                  limit_x;
  logic [ebrb_pkg::LINELEN_W-1:0]   len_sat;
  logic                             full;

  assign out_free = !ov_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (fill_r == PTR_LAST);

  assign sp_inc = (sp_r == PTR_LAST) ? '0 : sp_r + 1'b1;
  assign cp_inc = (cp_r == PTR_LAST) ? '0 : cp_r + 1'b1;

  // ring distance from the read pointer to just past the end byte
  assign line_span = ({1'b0, sp_inc} >= {1'b0, rp_r})
                   ? ({1'b0, sp_inc} - {1'b0, rp_r})
                   : ({1'b0, sp_inc} + DEPTH_X - {1'b0, rp_r});

  assign len_x   = CMPW'(len_r);
  assign limit_x = (CMPW'(maxlen_r) > LL_MAX) ? LL_MAX : CMPW'(maxlen_r);
  assign len_sat = (len_x > LL_MAX) ? ebrb_pkg::LINELEN_W'(LL_MAX)
                                    : ebrb_pkg::LINELEN_W'(len_x);

  always_comb begin
    state_nxt  = state_r;
    wp_nxt     = wp_r;
    rp_nxt     = rp_r;
    sp_nxt     = sp_r;
    cp_nxt     = cp_r;
    fill_nxt   = fill_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    rdy_nxt    = rdy_r;
    eol_nxt    = cfg_wr_en ? cfg_wr_data : eol_r;
    maxlen_nxt = maxlen_r;
    ost_nxt    = ost_r;
    odat_nxt   = odat_r;
    olen_nxt   = olen_r;
    olast_nxt  = olast_r;
    ov_nxt     = out_stall ? ov_r : 1'b0;
    ram_wr_en  = 1'b0;
    ram_rd_en  = 1'b0;
    ram_rd_addr = sp_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (ebrb_pkg::action_t'(in_action))
            ebrb_pkg::ACT_PUSH: begin
              ov_nxt    = 1'b1;
              odat_nxt  = '0;
              olen_nxt  = '0;
              olast_nxt = 1'b1;
              if (full) begin
                ost_nxt = ebrb_pkg::ST_FULL;
              end else begin
                ost_nxt   = ebrb_pkg::ST_OK;
                ram_wr_en = 1'b1;
                wp_nxt    = (wp_r == PTR_LAST) ? '0 : wp_r + 1'b1;
                fill_nxt  = fill_r + 1'b1;
                rdy_nxt   = 1'b1;
              end
            end
            ebrb_pkg::ACT_CLEAR: begin
              wp_nxt    = '0;
              rp_nxt    = '0;
              sp_nxt    = '0;
              fill_nxt  = '0;
              rdy_nxt   = 1'b0;
              ov_nxt    = 1'b1;
              ost_nxt   = ebrb_pkg::ST_OK;
              odat_nxt  = '0;
              olen_nxt  = '0;
              olast_nxt = 1'b1;
            end
            ebrb_pkg::ACT_GET: begin
              if (!rdy_r) begin
                ov_nxt    = 1'b1;
                ost_nxt   = ebrb_pkg::ST_NO_DATA;
                odat_nxt  = '0;
                olen_nxt  = '0;
                olast_nxt = 1'b1;
              end else begin
                maxlen_nxt = in_max_length;
                state_nxt  = S_SRD;
              end
            end
            default: begin
              // unused action code: taken with no transaction out
            end
          endcase
        end
      end

      S_SRD: begin
        if (sp_r == wp_r) begin
          if (out_free) begin
            ov_nxt    = 1'b1;
            ost_nxt   = full ? ebrb_pkg::ST_NO_EOL_FULL : ebrb_pkg::ST_NO_EOL;
            odat_nxt  = '0;
            olen_nxt  = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          ram_rd_en = 1'b1;
          state_nxt = S_SCMP;
        end
      end

      S_SCMP: begin
        sp_nxt = sp_inc;
        if (ram_rd_data == eol_r) begin
          len_nxt   = PW'(line_span);
          state_nxt = S_LCHK;
        end else begin
          state_nxt = S_SRD;
        end
      end

      S_LCHK: begin
        if (len_x > limit_x) begin
          if (out_free) begin
            // drop the line; data ready flag is left as is
            rp_nxt    = sp_r;
            fill_nxt  = (fill_r >= len_r) ? fill_r - len_r : '0;
            ov_nxt    = 1'b1;
            ost_nxt   = ebrb_pkg::ST_TOO_LONG;
            odat_nxt  = '0;
            olen_nxt  = len_sat;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cp_nxt    = rp_r;
          rem_nxt   = len_r;
          state_nxt = S_CRD;
        end
      end

      S_CRD: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = cp_r;
        state_nxt   = S_CEM;
      end

      S_CEM: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = ebrb_pkg::ST_OK;
          odat_nxt  = ram_rd_data;
          olen_nxt  = len_sat;
          olast_nxt = (rem_r == PW'(1));
          cp_nxt    = cp_inc;
          rem_nxt   = rem_r - 1'b1;
          if (rem_r == PW'(1)) begin
            rp_nxt    = sp_r;
            fill_nxt  = (fill_r >= len_r) ? fill_r - len_r : '0;
            if (fill_r <= len_r) begin
              rdy_nxt = 1'b0;
            end
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CRD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      wp_r    <= '0;
      rp_r    <= '0;
      sp_r    <= '0;
      fill_r  <= '0;
      rdy_r   <= 1'b0;
      eol_r   <= ebrb_pkg::EOL_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wp_r    <= wp_nxt;
      rp_r    <= rp_nxt;
      sp_r    <= sp_nxt;
      fill_r  <= fill_nxt;
      rdy_r   <= rdy_nxt;
      eol_r   <= eol_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_r     <= cp_nxt;
    len_r    <= len_nxt;
    rem_r    <= rem_nxt;
    maxlen_r <= maxlen_nxt;
    ost_r    <= ost_nxt;
    odat_r   <= odat_nxt;
    olen_r   <= olen_nxt;
    olast_r  <= olast_nxt;
  end

  assign ram_wr_addr     = wp_r;
  assign ram_wr_data     = in_data_in;
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_data_out    = odat_r;
  assign out_line_length = olen_r;
  assign out_last        = olast_r;

endmodule

// ----- rtl/core/eol_framed_byte_ring_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eol_framed_byte_ring_buffer
// Byte ring buffer that returns stored data as lines ended by a set byte.
//
// Input channel (in_valid / in_stall) carries one action per transaction:
// push a byte, get the next line, or clear. The result channel
// (out_valid / out_stall) returns status transactions; a found line comes
// out one byte per transaction with out_last on its final byte.
// cfg_wr_en / cfg_wr_data set the end-of-line byte; the user must do so only
// while the block is idle; the block does not enforce this. Push, clear and
// get without new data answer in the cycle after acceptance. A get scans
// stored bytes from where the last search stopped, reading then comparing
// each, then copies the line, reading then sending each byte; the byte memory
// has a single read port with registered read. After a push or clear the next
// transaction is taken as soon as the output register is free. Only one get
// is worked on at a time. A stall on the result channel holds the output
// register and pauses the copy and the search answer, not the scan; the input
// channel is stalled until the get is done. Reset empties the buffer and
// restores newline as end byte; memory is left as is, needing no clearing pass.
// ----------------------------------------------------------------------------
module eol_framed_byte_ring_buffer #(
  parameter int DEPTH = ebrb_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ebrb_pkg::ACTION_W-1:0]  in_action,
  input  logic [ebrb_pkg::BYTE_W-1:0]    in_data_in,
  input  logic [ebrb_pkg::MAXLEN_W-1:0]  in_max_length,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ebrb_pkg::STATUS_W-1:0]  out_status,
  output logic [ebrb_pkg::BYTE_W-1:0]    out_data_out,
  output logic [ebrb_pkg::LINELEN_W-1:0] out_line_length,
  output logic                           out_last,
  input  logic                           cfg_wr_en,
  input  logic [ebrb_pkg::BYTE_W-1:0]    cfg_wr_data
);

  localparam int PW = $clog2(DEPTH);

  logic                        ram_wr_en;
  logic [PW-1:0]               ram_wr_addr;
  logic [ebrb_pkg::BYTE_W-1:0] ram_wr_data;
  logic                        ram_rd_en;
  logic [PW-1:0]               ram_rd_addr;
  logic [ebrb_pkg::BYTE_W-1:0] ram_rd_data;

  ebrb_ram #(
    .WIDTH (ebrb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ebrb_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_data_in      (in_data_in),
    .in_max_length   (in_max_length),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_data_out    (out_data_out),
    .out_line_length (out_line_length),
    .out_last        (out_last),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .ram_wr_en       (ram_wr_en),
    .ram_wr_addr     (ram_wr_addr),
    .ram_wr_data     (ram_wr_data),
    .ram_rd_en       (ram_rd_en),
    .ram_rd_addr     (ram_rd_addr),
    .ram_rd_data     (ram_rd_data)
  );

endmodule
